FILE: src/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value text tokenizer
// Payload structs, token kind codes, character codes, controller states,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kvt_pkg;

   // input beat: one text byte or an end-of-input mark
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   // result beat: one token
   typedef struct packed {
      logic [7:0] token_byte;
      logic [2:0] token_kind;
      logic       last_of_run;
   } rsp_type;

   // token kinds
   localparam logic [2:0] KIND_KEY_BYTE   = 3'd0;
   localparam logic [2:0] KIND_KEY_END    = 3'd1;
   localparam logic [2:0] KIND_VALUE_BYTE = 3'd2;
   localparam logic [2:0] KIND_PAIR_END   = 3'd3;
   localparam logic [2:0] KIND_DISCARD    = 3'd4;

   // special characters
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   // what one input byte does
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_COMMENT_LF,
      ACT_EMIT_ESC,
      ACT_ESC_DROP,
      ACT_SET_ESC,
      ACT_HASH,
      ACT_QUOTE,
      ACT_KEY_END,
      ACT_FINISH,
      ACT_HOLD,
      ACT_FLUSH
   } act_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH_RD,
      ST_FLUSH_WR,
      ST_EMIT_CHAR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_input;
      logic do_action;
      logic flush_start;
      logic flush_emit;
      logic emit_char;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single_token;
      logic is_flush;
      logic count_zero;
      logic flush_last;
      logic out_free;
   } status_type;

endpackage

FILE: src/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath: byte classifier, parser flags, blank store and output register
// Classifies the captured byte against the parser flags, applies the
// state updates the controller commands and loads the result register.
// ----------------------------------------------------------------------------
module kvt_datapath import kvt_pkg::*; #(
   parameter int BLANK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   localparam int IW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
   localparam int CW = $clog2(BLANK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BLANK_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   req_type       in_ff, in_in;
   logic          in_comment_ff, in_comment_in;
   logic          esc_ff, esc_in;
   logic          quote_ff, quote_in;
   logic          key_ff, key_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [7:0] c;
   logic       blank;
   act_type    action;
   logic       ram_we;
   logic [7:0] ram_rdata;
   logic       out_load;
   logic       out_free;
   rsp_type    out_beat;
   logic       fin_en;
   logic       fin_complete;
   logic [2:0] data_kind;
   logic       seen_upd;

   assign c = in_ff.text_byte;
   assign blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign data_kind = key_ff ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
   assign seen_upd = blank ? seen_ff : 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // classify the captured byte
   always_comb begin
      action = ACT_NONE;
      if (in_ff.end_of_input) begin
         action = ACT_FINISH;
      end else if (in_comment_ff) begin
         action = (c == CHAR_NEWLINE) ? ACT_COMMENT_LF : ACT_NONE;
      end else if (blank && (c != CHAR_NEWLINE) && !seen_ff) begin
         action = ACT_NONE;
      end else if (esc_ff) begin
         action = (c != 8'd0) ? ACT_EMIT_ESC : ACT_ESC_DROP;
      end else if (c == CHAR_BACKSLASH) begin
         action = ACT_SET_ESC;
      end else if ((c == CHAR_HASH) && !quote_ff) begin
         action = ACT_HASH;
      end else if (c == CHAR_QUOTE) begin
         action = ACT_QUOTE;
      end else if ((c == CHAR_EQUAL) && !quote_ff && key_ff) begin
         action = ACT_KEY_END;
      end else if (c == CHAR_NEWLINE) begin
         action = ACT_FINISH;
      end else if (blank && !quote_ff) begin
         action = ACT_HOLD;
      end else begin
         action = ACT_FLUSH;
      end
   end

   // status toward the controller
   always_comb begin
      status.single_token = (action == ACT_EMIT_ESC) || (action == ACT_HASH) ||
                            (action == ACT_KEY_END) || (action == ACT_FINISH);
      status.is_flush     = (action == ACT_FLUSH);
      status.count_zero   = (count_ff == '0);
      status.flush_last   = ((idx_ff + ONE_C) == count_ff);
      status.out_free     = out_free;
   end

   // next state of flags, counters and output beat
   always_comb begin
      in_in         = in_ff;
      in_comment_in = in_comment_ff;
      esc_in        = esc_ff;
      quote_in      = quote_ff;
      key_in        = key_ff;
      seen_in       = seen_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ram_we        = 1'b0;
      out_load      = 1'b0;
      out_beat      = '0;
      fin_en        = 1'b0;
      fin_complete  = 1'b0;

      if (cmd.load_input) begin
         in_in = req_payload;
      end

      // single-step actions
      if (cmd.do_action) begin
         case (action)
            ACT_COMMENT_LF: begin
               in_comment_in = 1'b0;
            end
            ACT_EMIT_ESC: begin
               out_load             = 1'b1;
               out_beat.token_byte  = c;
               out_beat.token_kind  = data_kind;
               out_beat.last_of_run = 1'b1;
               esc_in               = 1'b0;
               seen_in              = seen_upd;
            end
            ACT_ESC_DROP: begin
               esc_in  = 1'b0;
               seen_in = seen_upd;
            end
            ACT_SET_ESC: begin
               esc_in  = 1'b1;
               seen_in = 1'b1;
            end
            ACT_HASH: begin
               seen_in       = 1'b1;
               in_comment_in = 1'b1;
               fin_en        = 1'b1;
               fin_complete  = 1'b1;
            end
            ACT_QUOTE: begin
               quote_in = !quote_ff;
               seen_in  = 1'b1;
            end
            ACT_KEY_END: begin
               seen_in      = 1'b1;
               fin_en       = 1'b1;
               fin_complete = 1'b0;
            end
            ACT_FINISH: begin
               fin_en       = 1'b1;
               fin_complete = 1'b1;
            end
            ACT_HOLD: begin
               if (count_ff < DEPTH_C) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + ONE_C;
               end
            end
            default: begin
            end
         endcase
      end

      // end of a part: discard marker or part switch
      if (fin_en) begin
         out_load             = 1'b1;
         out_beat.token_byte  = 8'd0;
         out_beat.last_of_run = 1'b1;
         if (fin_complete && key_ff) begin
            out_beat.token_kind = KIND_DISCARD;
         end else begin
            out_beat.token_kind = key_ff ? KIND_KEY_END : KIND_PAIR_END;
            key_in              = !key_ff;
            seen_in             = 1'b0;
            count_in            = '0;
         end
      end

      // held blank flush
      if (cmd.flush_start) begin
         idx_in  = '0;
         seen_in = 1'b1;
      end
      if (cmd.flush_emit) begin
         out_load             = 1'b1;
         out_beat.token_byte  = ram_rdata;
         out_beat.token_kind  = data_kind;
         out_beat.last_of_run = 1'b0;
         idx_in               = idx_ff + ONE_C;
      end
      if (cmd.emit_char) begin
         out_load             = 1'b1;
         out_beat.token_byte  = c;
         out_beat.token_kind  = data_kind;
         out_beat.last_of_run = 1'b1;
         count_in             = '0;
         seen_in              = 1'b1;
      end

      // output register
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_beat;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         esc_ff        <= 1'b0;
         quote_ff      <= 1'b0;
         key_ff        <= 1'b1;
         seen_ff       <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_comment_ff <= in_comment_in;
         esc_ff        <= esc_in;
         quote_ff      <= quote_in;
         key_ff        <= key_in;
         seen_ff       <= seen_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   // held blank store
   kvt_ram #(
      .WIDTH (8),
      .DEPTH (BLANK_DEPTH)
   ) u_blank_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (c),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // held blank count stays within the store
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("held blank count beyond depth");

   // a flush beat only reads a written entry
   assert property (@(posedge clock) disable iff (reset)
      cmd.flush_emit |-> (idx_ff < count_ff))
      else $error("flush read past held blanks");

   // the output register is never overwritten while a beat waits
   assert property (@(posedge clock) disable iff (reset) out_load |-> out_free)
      else $error("result beat overwritten");

endmodule

FILE: src/kvt_controller.sv
// ----------------------------------------------------------------------------
// kvt_controller: sequencer of the tokenizer
// Accepts one input beat at a time, then steps the datapath through the
// action of that byte, including the flush of held blanks.
// ----------------------------------------------------------------------------
module kvt_controller import kvt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_flush) begin
               if (status.count_zero) begin
                  if (status.out_free) begin
                     cmd.emit_char = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  cmd.flush_start = 1'b1;
                  state_in        = ST_FLUSH_RD;
               end
            end else if (status.single_token) begin
               if (status.out_free) begin
                  cmd.do_action = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.do_action = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_WR;
         end
         ST_FLUSH_WR: begin
            if (status.out_free) begin
               cmd.flush_emit = 1'b1;
               state_in       = status.flush_last ? ST_EMIT_CHAR : ST_FLUSH_RD;
            end
         end
         ST_EMIT_CHAR: begin
            if (status.out_free) begin
               cmd.emit_char = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // an accepted beat always starts its action next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_input |=> (state_ff == ST_EXEC))
      else $error("accepted beat not executed");

   // at most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("conflicting datapath commands");

   // input is only open while idle
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (state_ff == ST_IDLE))
      else $error("input open while busy");

endmodule

FILE: src/key_value_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// key_value_text_tokenizer_core: streaming key=value line tokenizer
// Takes one text byte per input beat and emits tagged key and value bytes
// followed by key-end, pair-end or key-discarded markers.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_valid / req_stall / req_payload (text byte or end mark).
//   rsp channel: rsp_valid / rsp_stall / rsp_payload, zero or more beats per
//   input beat; last_of_run marks the final beat of an input.
//   An input is taken in the idle state and worked on in the next cycle; each
//   result is registered and shows on rsp_valid in the cycle after it is
//   loaded. A non-blank byte that releases held blanks steps through a read
//   state and an emit state per held blank, set by the registered read of the
//   held blank memory, then emits the byte itself.
//   req_stall is high while an item is being worked on.
//   When the receiver stalls, the result waits in the output register and
//   the sequencer holds before its next result until it is taken; a new input
//   is still taken while the last result of the previous one waits.
//   Reset clears the parser flags, the held blank count and the output valid
//   flag; the held blank memory needs no clearing.
// ----------------------------------------------------------------------------
module key_value_text_tokenizer_core import kvt_pkg::*; #(
   parameter int BLANK_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   kvt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, blank store and output register
   kvt_datapath #(
      .BLANK_DEPTH (BLANK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
